@@ hw/rtl/sorted_list_table_assert.svh @@
// ----------------------------------------------------------------------------
// Sorted list table assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SLT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted list table check failed");
// Property where an antecedent implies a consequent in the next cycle.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list table sequence check failed");
`else
`define SLT_ASSERT_ALWAYS(label, clk, rst, cond)
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/slt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table package
// Request and status codes, field widths and the per-cell command struct.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int KEY_W    = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_LOOKUP  = 3'd2,
    REQ_RSTCUR  = 3'd3,
    REQ_READ    = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ABSENT   = 2'd2,
    STAT_PAST_END = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    clr;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

@@ hw/rtl/slt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table channels
// Valid/ready request and result interfaces.
// ----------------------------------------------------------------------------
interface slt_req_if;
  logic                             valid;
  logic                             ready;
  logic [slt_pkg::REQ_W-1:0]        req_type;
  logic signed [slt_pkg::KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface slt_res_if;
  logic                             valid;
  logic                             ready;
  logic [slt_pkg::STATUS_W-1:0]     status;
  logic                             found;
  logic signed [slt_pkg::KEY_W-1:0] value;
  logic [slt_pkg::COUNT_W-1:0]      count;
  logic                             full_res;

  modport source (output valid, output status, output found, output value,
                  output count, output full_res, input ready);
  modport sink (input valid, input status, input found, input value,
                input count, input full_res, output ready);
endinterface

@@ hw/rtl/slt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table cell
// Holds one key and its occupied flag; shifts with its neighbours.
// ----------------------------------------------------------------------------
module slt_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  slt_pkg::cell_cmd_t               cmd,
  input  logic signed [slt_pkg::KEY_W-1:0] left_entry,
  input  logic                             left_lt,
  input  logic                             left_occ,
  input  logic signed [slt_pkg::KEY_W-1:0] right_entry,
  input  logic                             right_occ,
  output logic signed [slt_pkg::KEY_W-1:0] entry,
  output logic                             occ,
  output logic                             lt,
  output logic                             eq
);

  logic signed [slt_pkg::KEY_W-1:0] entry_next;
  logic                             occ_next;

  assign lt = occ && (entry < cmd.key);
  assign eq = occ && (entry == cmd.key);

  // On insert, cells holding smaller keys stay; the first other cell takes
  // the key and the rest take their left neighbour. On delete, cells at or
  // above the key take their right neighbour.
  always_comb begin
    entry_next = entry;
    occ_next   = occ;
    if (cmd.clr) begin
      occ_next = 1'b0;
    end else if (cmd.ins) begin
      if (!lt) begin
        entry_next = left_lt ? cmd.key : left_entry;
      end
      occ_next = lt | left_occ;
    end else if (cmd.del) begin
      if (!lt) begin
        entry_next = right_entry;
        occ_next   = right_occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

@@ hw/rtl/sorted_list_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table
// Ascending list of signed keys held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | req_type, key
//  res     | out       | status, found, value, count, full_res
//
// Every request is handled at once: all cells compare against the key in parallel
// and shift in place, and the result is registered for the next cycle.
// A new request is taken whenever the result register is empty or its
// result is being taken, so back-to-back requests run at one per cycle while results are taken.
// Reset clears the occupied flags, the count and the read cursor at once;
// there is no clearing pass. The stored keys themselves are not reset.
module sorted_list_table #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  slt_req_if.sink         req,
  slt_res_if.source       res
);

  `include "sorted_list_table_assert.svh"

  // Width of the count and the cursor, which both run from 0 to DEPTH.
  localparam int CW = $clog2(DEPTH + 1);

  // Cell chain signals.
  logic signed [slt_pkg::KEY_W-1:0] entry_a [DEPTH];
  logic [DEPTH-1:0]                 occ_v;
  logic [DEPTH-1:0]                 lt_v;
  logic [DEPTH-1:0]                 eq_v;
  slt_pkg::cell_cmd_t               cmd;

  // Control registers.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;

  // Result register.
  logic                             out_valid;
  slt_pkg::status_t                 status_next;
  logic                             found_next;
  logic signed [slt_pkg::KEY_W-1:0] value_next;
  slt_pkg::status_t                 status_q;
  logic                             found_q;
  logic signed [slt_pkg::KEY_W-1:0] value_q;
  logic [slt_pkg::COUNT_W-1:0]      count_q;
  logic                             full_q;

  logic                             accept;
  logic                             full;
  logic                             any_eq;
  logic signed [slt_pkg::KEY_W-1:0] rd_val;
  slt_pkg::req_t                    op;

  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign op        = slt_pkg::req_t'(req.req_type);
  assign full      = (count == CW'(DEPTH));
  assign any_eq    = |eq_v;

  // The broadcast command only enables a shift when the request succeeds,
  // so a full insert or an absent delete leaves the chain untouched.
  always_comb begin
    cmd.key = req.key;
    cmd.ins = accept && (op == slt_pkg::REQ_INSERT) && !full;
    cmd.del = accept && (op == slt_pkg::REQ_DELETE) && any_eq;
    cmd.clr = accept && (op == slt_pkg::REQ_CLEAR);
  end

  // Each cell sees its neighbours. The head cell sees an occupied neighbour
  // holding a smaller key, so an insert lands there when nothing is smaller;
  // the tail cell sees an empty neighbour, so a delete empties it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [slt_pkg::KEY_W-1:0] l_entry;
    logic                             l_lt;
    logic                             l_occ;
    logic signed [slt_pkg::KEY_W-1:0] r_entry;
    logic                             r_occ;

    if (i == 0) begin : g_head
      assign l_entry = '0;
      assign l_lt    = 1'b1;
      assign l_occ   = 1'b1;
    end else begin : g_body
      assign l_entry = entry_a[i-1];
      assign l_lt    = lt_v[i-1];
      assign l_occ   = occ_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_entry = '0;
      assign r_occ   = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_a[i+1];
      assign r_occ   = occ_v[i+1];
    end

    slt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_entry  (l_entry),
      .left_lt     (l_lt),
      .left_occ    (l_occ),
      .right_entry (r_entry),
      .right_occ   (r_occ),
      .entry       (entry_a[i]),
      .occ         (occ_v[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  // The key under the cursor is picked by an AND-OR over the cells.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cursor == CW'(i)) begin
        rd_val = rd_val | entry_a[i];
      end
    end
  end

  // Result and control updates for the request being accepted.
  always_comb begin
    status_next = slt_pkg::STAT_OK;
    found_next  = 1'b0;
    value_next  = '0;
    count_next  = count;
    cursor_next = cursor;
    case (op)
      slt_pkg::REQ_INSERT: begin
        if (full) begin
          status_next = slt_pkg::STAT_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      slt_pkg::REQ_DELETE: begin
        if (any_eq) begin
          count_next = count - CW'(1);
        end else begin
          status_next = slt_pkg::STAT_ABSENT;
        end
      end
      slt_pkg::REQ_LOOKUP: begin
        found_next = any_eq;
        value_next = any_eq ? req.key : '0;
      end
      slt_pkg::REQ_RSTCUR: begin
        cursor_next = '0;
      end
      slt_pkg::REQ_READ: begin
        if (cursor < count) begin
          value_next  = rd_val;
          cursor_next = cursor + CW'(1);
        end else begin
          status_next = slt_pkg::STAT_PAST_END;
        end
      end
      slt_pkg::REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      found_q  <= found_next;
      value_q  <= value_next;
      count_q  <= slt_pkg::COUNT_W'(count_next);
      full_q   <= (count_next == CW'(DEPTH));
    end
  end

  assign res.valid    = out_valid;
  assign res.status   = status_q;
  assign res.found    = found_q;
  assign res.value    = value_q;
  assign res.count    = count_q;
  assign res.full_res = full_q;

  // The occupied flags of the chain always agree with the count.
  `SLT_ASSERT_ALWAYS(a_occ_count, clk, rst, count == CW'($countones(occ_v)))
  // Occupied cells are packed at the head of the chain.
  `SLT_ASSERT_ALWAYS(a_occ_packed, clk, rst, ((occ_v + 1'b1) & occ_v) == '0)
  // A successful insert grows the count by exactly one.
  `SLT_ASSERT_NEXT(a_ins_grow, clk, rst, cmd.ins, count == $past(count) + CW'(1))

endmodule
